[src/srar_pkg.sv]
// ----------------------------------------------------------------------------
// srar_pkg
// Shared constants, item types and the line character table of the reporter.
// ----------------------------------------------------------------------------
package srar_pkg;

  localparam int SAMPLES_PER_READING = 10;

  localparam int TEMP_SCALE = 330;
  localparam int MV_SCALE   = 3300;
  localparam int ADC_FULL   = 1023;
  localparam int HUM_DIV    = 3;
  localparam int DEC_BASE   = 10;

  localparam int SAMPLE_W = 10;
  localparam int NUM_W    = $clog2(ADC_FULL * MV_SCALE + 1);
  localparam int DEN_W    = 10;
  localparam int CNT_W    = $clog2(SAMPLES_PER_READING + 1);
  localparam int SUM_W    = $clog2(SAMPLES_PER_READING * TEMP_SCALE + 1);
  localparam int VAL_W    = $clog2(MV_SCALE + 1);
  localparam int PREV_W   = $clog2(TEMP_SCALE + 1);

  // rounded-up reciprocals scaled by 2^REC_SH, exact over the numerator range
  localparam int REC_SH = 32;
  localparam int REC_W  = REC_SH + 1;
  localparam logic [REC_W-1:0] REC_ADC =
    REC_W'(((64'd1 << REC_SH) + 64'(ADC_FULL) - 64'd1) / 64'(ADC_FULL));
  localparam logic [REC_W-1:0] REC_HUM =
    REC_W'(((64'd1 << REC_SH) + 64'(HUM_DIV) - 64'd1) / 64'(HUM_DIV));
  localparam logic [REC_W-1:0] REC_DEC =
    REC_W'(((64'd1 << REC_SH) + 64'(DEC_BASE) - 64'd1) / 64'(DEC_BASE));
  localparam logic [REC_W-1:0] REC_AVG =
    REC_W'(((64'd1 << REC_SH) + 64'(SAMPLES_PER_READING) - 64'd1) /
           64'(SAMPLES_PER_READING));

  localparam int NDIG   = 8;
  localparam int DIG_W  = 4;
  localparam int DCNT_W = $clog2(NDIG);

  localparam int HUM_LEN = 24;
  localparam int TEM_LEN = 30;
  localparam int IDX_W   = $clog2(TEM_LEN);

  localparam logic [8*HUM_LEN-1:0] HUM_LINE = "Vh=3.300V | Humedad=099%";
  localparam logic [8*TEM_LEN-1:0] TEM_LINE = "|Vt=3.300V | Temperatura=99C\015\012";

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  localparam logic KIND_HUM  = 1'b0;
  localparam logic KIND_TEMP = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [REC_W-1:0]  recip;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

  typedef logic [NDIG-1:0][DIG_W-1:0] digits_t;

  typedef struct packed {
    logic    start;
    logic    kind;
    digits_t digits;
  } emit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } emit_rsp_t;

  function automatic logic [7:0] to_ascii(input logic [DIG_W-1:0] d);
    return ASCII_ZERO + {{(8 - DIG_W){1'b0}}, d};
  endfunction

  // template character with the decimal digits patched in
  function automatic logic [7:0] line_char(input logic kind, input logic [IDX_W-1:0] idx,
                                           input digits_t dig);
    logic [7:0] ch;
    ch = 8'h00;
    if (kind == KIND_HUM) begin
      if (idx < IDX_W'(HUM_LEN)) begin
        ch = HUM_LINE[8 * (HUM_LEN - 1 - int'(idx)) +: 8];
      end
      case (idx)
        IDX_W'(3):  ch = to_ascii(dig[3]);
        IDX_W'(5):  ch = to_ascii(dig[2]);
        IDX_W'(6):  ch = to_ascii(dig[1]);
        IDX_W'(7):  ch = to_ascii(dig[0]);
        IDX_W'(20): ch = to_ascii(dig[7]);
        IDX_W'(21): ch = to_ascii(dig[6]);
        IDX_W'(22): ch = to_ascii(dig[5]);
        default: ;
      endcase
    end else begin
      if (idx < IDX_W'(TEM_LEN)) begin
        ch = TEM_LINE[8 * (TEM_LEN - 1 - int'(idx)) +: 8];
      end
      case (idx)
        IDX_W'(4):  ch = to_ascii(dig[3]);
        IDX_W'(6):  ch = to_ascii(dig[2]);
        IDX_W'(7):  ch = to_ascii(dig[1]);
        IDX_W'(8):  ch = to_ascii(dig[0]);
        IDX_W'(25): ch = to_ascii(dig[1]);
        IDX_W'(26): ch = to_ascii(dig[0]);
        default: ;
      endcase
    end
    return ch;
  endfunction

endpackage

[src/srar_div.sv]
// ----------------------------------------------------------------------------
// srar_div
// Shared constant divider: reciprocal product, then remainder, on one multiplier.
// ----------------------------------------------------------------------------
module srar_div (
  input  logic                clk,
  input  logic                rst_n,
  input  srar_pkg::div_req_t  req,
  output srar_pkg::div_rsp_t  rsp
);

  logic                                        busy_r, busy_nxt;
  logic                                        done_r, done_nxt;
  logic                                        phase_r, phase_nxt;
  logic [srar_pkg::NUM_W-1:0]                  num_r, num_nxt;
  logic [srar_pkg::DEN_W-1:0]                  den_r, den_nxt;
  logic [srar_pkg::REC_W-1:0]                  recip_r, recip_nxt;
  logic [srar_pkg::DEN_W-1:0]                  rem_r, rem_nxt;
  logic [srar_pkg::NUM_W-1:0]                  quo_r, quo_nxt;
  logic [srar_pkg::NUM_W-1:0]                  mul_a;
  logic [srar_pkg::REC_W-1:0]                  mul_b;
  logic [srar_pkg::NUM_W+srar_pkg::REC_W-1:0]  prod;

  // first pass num * recip, second pass quo * den
  assign mul_a = phase_r ? quo_r : num_r;
  assign mul_b = phase_r ? {{(srar_pkg::REC_W - srar_pkg::DEN_W){1'b0}}, den_r} : recip_r;
  assign prod  = {{srar_pkg::REC_W{1'b0}}, mul_a} * {{srar_pkg::NUM_W{1'b0}}, mul_b};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    recip_nxt = recip_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      num_nxt   = req.num;
      den_nxt   = req.den;
      recip_nxt = req.recip;
    end else if (busy_r) begin
      if (!phase_r) begin
        quo_nxt   = prod[srar_pkg::REC_SH +: srar_pkg::NUM_W];
        phase_nxt = 1'b1;
      end else begin
        rem_nxt  = srar_pkg::DEN_W'(num_r - prod[srar_pkg::NUM_W-1:0]);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    recip_r <= recip_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

[src/srar_fmt.sv]
// ----------------------------------------------------------------------------
// srar_fmt
// Report line emitter: walks the line template and feeds the output register.
// ----------------------------------------------------------------------------
module srar_fmt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srar_pkg::emit_req_t  req,
  output srar_pkg::emit_rsp_t  rsp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srar_pkg::out_item_t  out_item
);

  logic                        busy_r, busy_nxt;
  logic [srar_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  srar_pkg::out_item_t         out_item_r, out_item_nxt;
  logic                        load;
  logic                        is_last;

  assign load    = busy_r && (!out_valid_r || out_ready);
  assign is_last = (req.kind == srar_pkg::KIND_HUM) ?
                   (idx_r == srar_pkg::IDX_W'(srar_pkg::HUM_LEN - 1)) :
                   (idx_r == srar_pkg::IDX_W'(srar_pkg::TEM_LEN - 1));

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.text_byte = srar_pkg::line_char(req.kind, idx_r, req.digits);
      out_item_nxt.last      = is_last;
      idx_nxt                = idx_r + srar_pkg::IDX_W'(1);
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = load && is_last;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[src/sensor_reading_ascii_reporter_unit.sv]
// ----------------------------------------------------------------------------
// sensor_reading_ascii_reporter_unit
// Turns tagged converter samples into ASCII report lines.
// ----------------------------------------------------------------------------
// in_item carries kind (0 humidity, 1 temperature) and a 10-bit sample, taken
// on in_valid & in_ready. out_item carries one text_byte per item, last marks
// the final character of a line. Both channels are valid/ready.
// One shared constant divider (reciprocal multiply, then remainder) does all
// scaling, averaging and digit splits. Humidity item: /1023, /3 and eight
// /10 steps, then 24 characters, one per cycle while the receiver is ready;
// the next item can be taken once the last character of the line is loaded
// into the output register. Temperature item: one /1023 step and no output,
// except every tenth one, which adds an average divide and four /10 steps
// and then 30 characters ending in CR LF.
// in_ready is high only while no item is in work; the last character of a
// line may still sit in the output register when the next item is taken.
// A stalled receiver holds the emitter and hence the whole unit.
// Synchronous reset clears the count, the sum and the previous reading.
// ----------------------------------------------------------------------------
module sensor_reading_ascii_reporter_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srar_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srar_pkg::out_item_t  out_item
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCALE = 6'b000010,
    ST_HDIV  = 6'b000100,
    ST_DIGIT = 6'b001000,
    ST_AVG   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic                          kind_r, kind_nxt;
  logic [srar_pkg::NUM_W-1:0]    prod_r, prod_nxt;
  logic [srar_pkg::VAL_W-1:0]    mv_r, mv_nxt;
  logic [srar_pkg::VAL_W-1:0]    h_r, h_nxt;
  logic [srar_pkg::VAL_W-1:0]    val_r, val_nxt;
  srar_pkg::digits_t             dig_r, dig_nxt;
  logic [srar_pkg::DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [srar_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [srar_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [srar_pkg::PREV_W-1:0]   prev_r, prev_nxt;
  logic                          div_start_r, div_start_nxt;
  logic                          emit_start_r, emit_start_nxt;

  srar_pkg::div_req_t            div_req;
  srar_pkg::div_rsp_t            div_rsp;
  srar_pkg::emit_req_t           emit_req;
  srar_pkg::emit_rsp_t           emit_rsp;

  logic [srar_pkg::CNT_W-1:0]    cnt_inc;
  logic [srar_pkg::PREV_W:0]     reading_sum;
  logic [srar_pkg::PREV_W-1:0]   reading;
  logic [srar_pkg::DCNT_W-1:0]   dcnt_last;

  assign cnt_inc     = cnt_r + srar_pkg::CNT_W'(1);
  assign reading_sum = {1'b0, div_rsp.quo[srar_pkg::PREV_W-1:0]} + {1'b0, prev_r};
  assign reading     = reading_sum[srar_pkg::PREV_W:1];
  assign dcnt_last   = (kind_r == srar_pkg::KIND_HUM) ?
                       srar_pkg::DCNT_W'(srar_pkg::NDIG - 1) :
                       srar_pkg::DCNT_W'(srar_pkg::NDIG / 2 - 1);

  assign in_ready = (state_r == ST_IDLE);

  // divider operands by step
  always_comb begin
    div_req.start = div_start_r;
    div_req.num   = '0;
    div_req.den   = '0;
    div_req.recip = '0;
    case (state_r)
      ST_SCALE: begin
        div_req.num   = prod_r;
        div_req.den   = srar_pkg::DEN_W'(srar_pkg::ADC_FULL);
        div_req.recip = srar_pkg::REC_ADC;
      end
      ST_HDIV: begin
        div_req.num   = srar_pkg::NUM_W'(mv_r);
        div_req.den   = srar_pkg::DEN_W'(srar_pkg::HUM_DIV);
        div_req.recip = srar_pkg::REC_HUM;
      end
      ST_DIGIT: begin
        div_req.num   = srar_pkg::NUM_W'(val_r);
        div_req.den   = srar_pkg::DEN_W'(srar_pkg::DEC_BASE);
        div_req.recip = srar_pkg::REC_DEC;
      end
      ST_AVG: begin
        div_req.num   = srar_pkg::NUM_W'(sum_r);
        div_req.den   = srar_pkg::DEN_W'(srar_pkg::SAMPLES_PER_READING);
        div_req.recip = srar_pkg::REC_AVG;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    prod_nxt       = prod_r;
    mv_nxt         = mv_r;
    h_nxt          = h_r;
    val_nxt        = val_r;
    dig_nxt        = dig_r;
    dcnt_nxt       = dcnt_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    prev_nxt       = prev_r;
    div_start_nxt  = 1'b0;
    emit_start_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt      = in_item.kind;
          prod_nxt      = srar_pkg::NUM_W'(in_item.sample) *
                          ((in_item.kind == srar_pkg::KIND_TEMP) ?
                           srar_pkg::NUM_W'(srar_pkg::TEMP_SCALE) :
                           srar_pkg::NUM_W'(srar_pkg::MV_SCALE));
          state_nxt     = ST_SCALE;
          div_start_nxt = 1'b1;
        end
      end
      ST_SCALE: begin
        if (div_rsp.done) begin
          if (kind_r == srar_pkg::KIND_HUM) begin
            mv_nxt        = div_rsp.quo[srar_pkg::VAL_W-1:0];
            state_nxt     = ST_HDIV;
            div_start_nxt = 1'b1;
          end else begin
            sum_nxt = sum_r + div_rsp.quo[srar_pkg::SUM_W-1:0];
            cnt_nxt = cnt_inc;
            if (cnt_inc == srar_pkg::CNT_W'(srar_pkg::SAMPLES_PER_READING)) begin
              state_nxt     = ST_AVG;
              div_start_nxt = 1'b1;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_HDIV: begin
        if (div_rsp.done) begin
          h_nxt         = div_rsp.quo[srar_pkg::VAL_W-1:0];
          val_nxt       = mv_r;
          dcnt_nxt      = '0;
          state_nxt     = ST_DIGIT;
          div_start_nxt = 1'b1;
        end
      end
      ST_AVG: begin
        if (div_rsp.done) begin
          prev_nxt      = reading;
          sum_nxt       = '0;
          cnt_nxt       = '0;
          val_nxt       = srar_pkg::VAL_W'(reading);
          dcnt_nxt      = '0;
          state_nxt     = ST_DIGIT;
          div_start_nxt = 1'b1;
        end
      end
      ST_DIGIT: begin
        if (div_rsp.done) begin
          dig_nxt[dcnt_r] = div_rsp.rem[srar_pkg::DIG_W-1:0];
          if (dcnt_r == dcnt_last) begin
            state_nxt      = ST_EMIT;
            emit_start_nxt = 1'b1;
          end else begin
            dcnt_nxt      = dcnt_r + srar_pkg::DCNT_W'(1);
            div_start_nxt = 1'b1;
            // humidity figure digits follow the millivolt digits
            if (dcnt_r == srar_pkg::DCNT_W'(srar_pkg::NDIG / 2 - 1)) begin
              val_nxt = h_r;
            end else begin
              val_nxt = div_rsp.quo[srar_pkg::VAL_W-1:0];
            end
          end
        end
      end
      ST_EMIT: begin
        if (emit_rsp.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      sum_r        <= '0;
      prev_r       <= '0;
      div_start_r  <= 1'b0;
      emit_start_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      sum_r        <= sum_nxt;
      prev_r       <= prev_nxt;
      div_start_r  <= div_start_nxt;
      emit_start_r <= emit_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    prod_r <= prod_nxt;
    mv_r   <= mv_nxt;
    h_r    <= h_nxt;
    val_r  <= val_nxt;
    dig_r  <= dig_nxt;
    dcnt_r <= dcnt_nxt;
  end

  assign emit_req.start  = emit_start_r;
  assign emit_req.kind   = kind_r;
  assign emit_req.digits = dig_r;

  srar_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  srar_fmt u_fmt (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (emit_req),
    .rsp       (emit_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef ASSERT_OFF
  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_emit_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_req.start |-> !emit_rsp.busy)
    else $error("line started while emitter busy");

  a_ready_after_line: assert property (@(posedge clk) disable iff (!rst_n)
    emit_rsp.done |=> in_ready)
    else $error("not ready after line end");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= srar_pkg::CNT_W'(srar_pkg::SAMPLES_PER_READING))
    else $error("sample count out of range");

  a_prev_range: assert property (@(posedge clk) disable iff (!rst_n)
    prev_r <= srar_pkg::PREV_W'(srar_pkg::TEMP_SCALE))
    else $error("previous reading out of range");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sensor reading ASCII reporter.
// ----------------------------------------------------------------------------
// Humidity and temperature samples are sent through a valid/ready driver fed
// from a queue of pending items. Each accepted item runs through a local model
// of the report lines, and every character that comes out is checked in order
// against it. Both sides insert random waits between items, with some calm
// stretches that have no waits at all.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MV_FULL      = 3300;
  localparam int DEG_FULL     = 330;
  localparam int CODE_MAX     = 1023;
  localparam int RANDOM_ITEMS = 420;
  localparam int SETTLE_CYC   = 200;
  localparam int MAX_REPORTS  = 40;
  localparam logic [7:0] CR_CHAR = 8'h0D;
  localparam logic [7:0] LF_CHAR = 8'h0A;

  typedef struct {
    srar_pkg::in_item_t item;
    int                 gap;
  } queued_sample_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  srar_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  srar_pkg::out_item_t out_item;

  queued_sample_t      pending_samples[$];
  srar_pkg::out_item_t expected_chars[$];

  logic [3:0]  temp_count = '0;
  logic [11:0] temp_sum = '0;
  logic [8:0]  prev_reading = '0;

  int failures = 0;
  int chars_checked = 0;
  int hum_lines = 0;
  int temp_lines = 0;
  int samples_taken = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int recv_stall = 0;

  sensor_reading_ascii_reporter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] dec_char(int v, int place);
    return 8'(int'(srar_pkg::ASCII_ZERO) + (v / place) % 10);
  endfunction

  // wait in cycles, with occasional stretches of no waiting
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = int'($urandom_range(15, 60));
    return int'($urandom_range(0, 12));
  endfunction

  function automatic logic [9:0] rand_sample();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 10'd0;
        1: return 10'd1;
        2: return 10'd1022;
        default: return 10'd1023;
      endcase
    end
    return 10'($urandom_range(0, CODE_MAX));
  endfunction

  function automatic void queue_sample(logic kind, logic [9:0] sample);
    queued_sample_t q;
    q.item.kind = kind;
    q.item.sample = sample;
    q.gap = pick_wait(send_calm);
    pending_samples.push_back(q);
  endfunction

  // report line model: humidity lines always, temperature every tenth sample
  function automatic void predict_report(srar_pkg::in_item_t it);
    string               line;
    logic [7:0]          txt[$];
    srar_pkg::out_item_t ch;
    int                  x;
    int                  mv;
    int                  hum;
    int                  avg;
    int                  rd;
    x = int'(it.sample);
    if (it.kind == srar_pkg::KIND_HUM) begin
      mv = x * MV_FULL / CODE_MAX;
      hum = mv / 3;
      line = "Vh=3.300V | Humedad=099%";
      line[3] = dec_char(mv, 1000);
      line[5] = dec_char(mv, 100);
      line[6] = dec_char(mv, 10);
      line[7] = dec_char(mv, 1);
      line[20] = dec_char(hum, 1000);
      line[21] = dec_char(hum, 100);
      line[22] = dec_char(hum, 10);
      for (int i = 0; i < line.len(); i++) txt.push_back(line[i]);
      hum_lines++;
    end else begin
      temp_sum = temp_sum + 12'(x * DEG_FULL / CODE_MAX);
      temp_count = temp_count + 4'd1;
      if (int'(temp_count) < srar_pkg::SAMPLES_PER_READING) return;
      avg = int'(temp_sum) / srar_pkg::SAMPLES_PER_READING;
      rd = (avg + int'(prev_reading)) / 2;
      prev_reading = 9'(rd);
      temp_sum = '0;
      temp_count = '0;
      line = "|Vt=3.300V | Temperatura=99C";
      line[4] = dec_char(rd, 1000);
      line[6] = dec_char(rd, 100);
      line[7] = dec_char(rd, 10);
      line[8] = dec_char(rd, 1);
      line[25] = dec_char(rd, 10);
      line[26] = dec_char(rd, 1);
      for (int i = 0; i < line.len(); i++) txt.push_back(line[i]);
      txt.push_back(CR_CHAR);
      txt.push_back(LF_CHAR);
      temp_lines++;
    end
    foreach (txt[i]) begin
      ch.text_byte = txt[i];
      ch.last = (i == txt.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_report(in_item);
        samples_taken++;
      end
      if (in_valid && !in_ready) begin
      end else if (pending_samples.size() != 0 && pending_samples[0].gap == 0) begin
        in_item <= pending_samples[0].item;
        in_valid <= 1'b1;
        void'(pending_samples.pop_front());
      end else begin
        in_valid <= 1'b0;
        if (pending_samples.size() != 0)
          pending_samples[0].gap = pending_samples[0].gap - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $error("unexpected item: text_byte %h last %b", out_item.text_byte, out_item.last);
        end else begin
          if (out_item.text_byte !== expected_chars[0].text_byte) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $error("text_byte mismatch: expected %h, actual %h",
                     expected_chars[0].text_byte, out_item.text_byte);
          end
          if (out_item.last !== expected_chars[0].last) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $error("last mismatch: expected %b, actual %b",
                     expected_chars[0].last, out_item.last);
          end
          void'(expected_chars.pop_front());
        end
        recv_stall = pick_wait(recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int         level;
    int         v;
    int         runs;
    logic [9:0] s;

    // extremes and bit patterns of humidity
    queue_sample(srar_pkg::KIND_HUM, 10'd0);
    queue_sample(srar_pkg::KIND_HUM, 10'd1023);
    queue_sample(srar_pkg::KIND_HUM, 10'h155);
    queue_sample(srar_pkg::KIND_HUM, 10'h2AA);
    queue_sample(srar_pkg::KIND_HUM, 10'd1);
    queue_sample(srar_pkg::KIND_HUM, 10'd310);
    // full-scale reading with a humidity item in the middle of it
    for (int i = 0; i < 10; i++) begin
      if (i == 5) queue_sample(srar_pkg::KIND_HUM, 10'd512);
      queue_sample(srar_pkg::KIND_TEMP, 10'd1023);
    end
    // alternating zero and 0x155 samples, averaged with the previous reading
    for (int i = 0; i < 10; i++)
      queue_sample(srar_pkg::KIND_TEMP, (i % 2) ? 10'h155 : 10'd0);

    while (pending_samples.size() < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // reading run around one level
          level = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? CODE_MAX : 0)
                                              : int'($urandom_range(0, CODE_MAX));
          for (int k = 0; k < srar_pkg::SAMPLES_PER_READING; k++) begin
            if ($urandom_range(0, 5) == 0) queue_sample(srar_pkg::KIND_HUM, rand_sample());
            if ($urandom_range(0, 7) == 0) begin
              s = rand_sample();
            end else begin
              v = level + int'($urandom_range(0, 80)) - 40;
              if (v < 0) v = 0;
              if (v > CODE_MAX) v = CODE_MAX;
              s = 10'(v);
            end
            queue_sample(srar_pkg::KIND_TEMP, s);
          end
        end
        6, 7, 8: queue_sample(srar_pkg::KIND_HUM, rand_sample());
        default: begin
          runs = int'($urandom_range(1, 5));
          for (int k = 0; k < runs; k++) queue_sample(srar_pkg::KIND_TEMP, rand_sample());
        end
      endcase
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);

    if (expected_chars.size() != 0) begin
      failures++;
      $error("%0d expected characters never arrived", expected_chars.size());
    end
    $display("sent %0d samples: %0d humidity lines, %0d temperature readings",
             samples_taken, hum_lines, temp_lines);
    $display("checked %0d characters, %0d failures", chars_checked, failures);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[sensor_reading_ascii_reporter_unit.f]
src/srar_pkg.sv
src/srar_div.sv
src/srar_fmt.sv
src/sensor_reading_ascii_reporter_unit.sv
tb/testbench.sv
